### hw/rtl/bte_pkg.sv
// ----------------------------------------------------------------------------
// bte_pkg
// Shared constants and widths for the boosted tree ensemble scorer.
// ----------------------------------------------------------------------------
package bte_pkg;

    localparam int TREE_W    = 6;
    localparam int NODE_W    = 6;
    localparam int FEAT_W    = 5;
    localparam int VAL_W     = 32;
    localparam int CNT_W     = 7;
    localparam int DEPTH_W   = 4;
    localparam int NADDR_W   = TREE_W + NODE_W;
    localparam int MAX_TREES = 64;
    localparam int MAX_DEPTH = 16;
    localparam int SUM_W     = 39;
    localparam int Q_W       = 16;
    localparam int NWORD_W   = 2 + 2 * NODE_W + FEAT_W + VAL_W;
    localparam int IN_W      = 128;
    localparam int OUT_W     = 40;

    // request kinds carried on tuser
    localparam logic [1:0] REQ_NODE   = 2'd0;
    localparam logic [1:0] REQ_WEIGHT = 2'd1;
    localparam logic [1:0] REQ_FEAT   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOTREES = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_NOFEAT  = 3'd3;
    localparam logic [2:0] ST_ZEROWGT = 3'd4;

endpackage

### hw/rtl/bte_div.sv
// ----------------------------------------------------------------------------
// bte_div
// Restoring divider: quotient = (mag << 15) / total, one bit per cycle.
// ----------------------------------------------------------------------------
module bte_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bte_pkg::SUM_W-1:0]   mag,
    input  logic [bte_pkg::SUM_W-1:0]   total,
    output logic                        done,
    output logic [bte_pkg::Q_W-1:0]     quot
);
    import bte_pkg::*;

    logic [SUM_W-1:0] rem_reg, rem_next;
    logic [SUM_W-1:0] den_reg;
    logic [Q_W-1:0]   q_reg, q_next;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             ge;
    logic [SUM_W-1:0] diff;

    // compare and subtract one quotient bit
    always_comb
    begin
        ge       = rem_reg >= den_reg;
        diff     = ge ? rem_reg - den_reg : rem_reg;
        rem_next = {diff[SUM_W-2:0], 1'b0};
        q_next   = {q_reg[Q_W-2:0], ge};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'(Q_W - 1))
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= mag;
            den_reg <= total;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign done = busy_reg && (cnt_reg == 5'(Q_W - 1));
    assign quot = q_next;

endmodule

### hw/rtl/boosted_tree_ensemble_score.sv
// ----------------------------------------------------------------------------
// boosted_tree_ensemble_score
// Boosted decision-tree ensemble scorer: node table, tree weights and feature
// vector in on-chip memories, tree walks by a sequencer, normalized score out.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                         Meaning
// s_axis    in   s_tvalid/s_tready/s_tdata/...   node, weight, feature requests
// m_axis    out  m_tvalid/m_tready/m_tdata       one result per last feature
// cfg       in   cfg_we/cfg_wdata                trees_in_use register
//
// Node, weight and plain feature requests are written straight into their memories.
// An evaluation walks each tree in turn: a node memory read per node, then a
// feature memory read for a branch node or a weight memory read for a leaf;
// then the divider forms the score, unless an error status ends it early.
// After reset a clearing pass over all 4096 node slots marks every one absent;
// s_tready stays low until it ends. A stalled result holds the sequencer.
// ----------------------------------------------------------------------------
module boosted_tree_ensemble_score (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // tree_index, node_index, is_leaf, leaf_vote, left_child, right_child,
    // feature_index, threshold, tree_weight, feature_value, one zero pad bit
    input  logic [bte_pkg::IN_W-1:0]     s_tdata,
    // req_type
    input  logic [1:0]                   s_tuser,
    input  logic                         s_tlast,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // score, probability, is_signal, status, four zero pad bits
    output logic [bte_pkg::OUT_W-1:0]    m_tdata,
    input  logic                         cfg_we,
    input  logic [bte_pkg::CNT_W-1:0]    cfg_wdata
);
    import bte_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_NODE  = 4'd2;
    localparam logic [3:0] S_FEAT  = 4'd3;
    localparam logic [3:0] S_WGT   = 4'd4;
    localparam logic [3:0] S_CHK   = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_DONE  = 4'd7;

    // unpack request
    logic [TREE_W-1:0] in_tree;
    logic [NODE_W-1:0] in_node, in_left, in_right;
    logic              in_leaf, in_vote;
    logic [FEAT_W-1:0] in_feat;
    logic [VAL_W-1:0]  in_thr, in_wgt, in_fval;

    assign in_tree  = s_tdata[5:0];
    assign in_node  = s_tdata[11:6];
    assign in_leaf  = s_tdata[12];
    assign in_vote  = s_tdata[13];
    assign in_left  = s_tdata[19:14];
    assign in_right = s_tdata[25:20];
    assign in_feat  = s_tdata[30:26];
    assign in_thr   = s_tdata[62:31];
    assign in_wgt   = s_tdata[94:63];
    assign in_fval  = s_tdata[126:95];

    // memories: node word is {present, leaf, vote, left, right, feat, thr}
    logic [NWORD_W:0]   node_mem [2**NADDR_W];
    logic [VAL_W-1:0]   wgt_mem  [MAX_TREES];
    logic [VAL_W-1:0]   feat_mem [2**FEAT_W];
    logic [NWORD_W:0]   node_q;
    logic [VAL_W-1:0]   wgt_q, feat_q;
    logic [NADDR_W-1:0] node_raddr;
    logic [FEAT_W-1:0]  feat_raddr;

    logic [3:0]         state_reg, state_next;
    logic [NADDR_W-1:0] clr_reg;
    logic [CNT_W-1:0]   trees_in_use_reg;
    logic [FEAT_W:0]    fcnt_reg, fcnt_next, efcnt_reg;
    logic [MAX_TREES-1:0] wvalid_reg;
    logic [CNT_W-1:0]   ntrees_reg;
    logic [TREE_W-1:0]  tree_reg, tree_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic               vote_reg;
    logic [NODE_W-1:0]  left_reg, right_reg;
    logic signed [VAL_W-1:0] thr_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [2:0]         status_reg, status_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   out_data_reg;

    logic               s_acc, eval_start, div_start, div_done;
    logic [Q_W-1:0]     div_q;
    logic [SUM_W-1:0]   mag;
    logic [CNT_W-1:0]   ntrees_in;
    logic [SUM_W-1:0]   w_ext;
    logic [CNT_W-1:0]   tree_inc;
    logic [Q_W-1:0]     score_q, quot_reg;
    logic               n_present, n_leaf, n_vote;
    logic [FEAT_W-1:0]  n_feat;
    logic [NODE_W-1:0]  child;

    assign s_tready   = (state_reg == S_IDLE);
    assign s_acc      = s_tvalid && s_tready;
    assign eval_start = s_acc && (s_tuser == REQ_FEAT) && s_tlast;
    assign ntrees_in  = (trees_in_use_reg > CNT_W'(MAX_TREES)) ? CNT_W'(MAX_TREES)
                                                                : trees_in_use_reg;
    assign n_present  = node_q[NWORD_W];
    assign n_leaf     = node_q[NWORD_W-1];
    assign n_vote     = node_q[NWORD_W-2];
    assign n_feat     = node_q[VAL_W+FEAT_W-1:VAL_W];
    assign w_ext      = wvalid_reg[tree_reg] ? SUM_W'(wgt_q) : '0;
    assign tree_inc   = {1'b0, tree_reg} + CNT_W'(1);
    assign child      = ($signed(feat_q) <= thr_reg) ? left_reg : right_reg;
    assign mag        = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign fcnt_next  = eval_start ? '0 :
                        (s_acc && s_tuser == REQ_FEAT) ? {1'b0, in_feat} + 1'b1 : fcnt_reg;

    // sequencer next state and memory read addresses
    always_comb
    begin
        state_next  = state_reg;
        tree_next   = tree_reg;
        depth_next  = depth_reg;
        sum_next    = sum_reg;
        total_next  = total_reg;
        status_next = status_reg;
        node_raddr  = {tree_reg, NODE_W'(0)};
        feat_raddr  = n_feat;
        div_start   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == '1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (eval_start)
                begin
                    tree_next   = '0;
                    depth_next  = '0;
                    sum_next    = '0;
                    total_next  = '0;
                    status_next = ST_OK;
                    node_raddr  = '0;
                    if (ntrees_in == '0)
                    begin
                        status_next = ST_NOTREES;
                        state_next  = S_DONE;
                    end
                    else
                        state_next = S_NODE;
                end
            end
            S_NODE:
            begin
                if (!n_present)
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
                else if (n_leaf)
                    state_next = S_WGT;
                else if ({1'b0, n_feat} >= efcnt_reg)
                begin
                    status_next = ST_NOFEAT;
                    state_next  = S_DONE;
                end
                else if (depth_reg == DEPTH_W'(MAX_DEPTH - 1))
                begin
                    status_next = ST_MISSING;
                    state_next  = S_DONE;
                end
                else
                    state_next = S_FEAT;
            end
            S_FEAT:
            begin
                node_raddr = {tree_reg, child};
                depth_next = depth_reg + 1'b1;
                state_next = S_NODE;
            end
            S_WGT:
            begin
                total_next = total_reg + w_ext;
                sum_next   = vote_reg ? sum_reg + $signed(w_ext) : sum_reg - $signed(w_ext);
                if (tree_inc == ntrees_reg)
                    state_next = S_CHK;
                else
                begin
                    tree_next  = tree_inc[TREE_W-1:0];
                    depth_next = '0;
                    node_raddr = {tree_inc[TREE_W-1:0], NODE_W'(0)};
                    state_next = S_NODE;
                end
            end
            S_CHK:
            begin
                if (total_reg == '0)
                begin
                    status_next = ST_ZEROWGT;
                    state_next  = S_DONE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_reg          <= '0;
            trees_in_use_reg <= '0;
            fcnt_reg         <= '0;
            wvalid_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fcnt_reg  <= fcnt_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (cfg_we)
                trees_in_use_reg <= cfg_wdata;
            if (s_acc && s_tuser == REQ_WEIGHT)
                wvalid_reg[in_tree] <= 1'b1;
            // hold result until taken, load a new one when done
            if (state_reg == S_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // walk payload registers
    always_ff @(posedge clk)
    begin
        tree_reg   <= tree_next;
        depth_reg  <= depth_next;
        sum_reg    <= sum_next;
        total_reg  <= total_next;
        status_reg <= status_next;
        if (eval_start)
        begin
            ntrees_reg <= ntrees_in;
            efcnt_reg  <= {1'b0, in_feat} + 1'b1;
        end
        if (state_reg == S_NODE)
        begin
            vote_reg  <= n_vote;
            left_reg  <= node_q[VAL_W+FEAT_W+2*NODE_W-1:VAL_W+FEAT_W+NODE_W];
            right_reg <= node_q[VAL_W+FEAT_W+NODE_W-1:VAL_W+FEAT_W];
            thr_reg   <= node_q[VAL_W-1:0];
        end
        if (div_done)
            quot_reg <= div_q;
        if (state_reg == S_DONE && (!out_valid_reg || m_tready))
            out_data_reg <= {4'b0, status_reg,
                             (status_reg == ST_OK) && !sum_reg[SUM_W-1] && (sum_reg != '0),
                             (status_reg == ST_OK) ? score_q ^ 16'h8000 : 16'h0000,
                             (status_reg == ST_OK) ? score_q : 16'h0000};
    end

    // sign and saturate the quotient
    always_comb
    begin
        if (sum_reg[SUM_W-1])
            score_q = -quot_reg;
        else if (quot_reg[Q_W-1])
            score_q = 16'h7FFF;
        else
            score_q = quot_reg;
    end

    // node memory: clearing pass or node write, one read port
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
            node_mem[clr_reg] <= '0;
        else if (s_acc && s_tuser == REQ_NODE)
            node_mem[{in_tree, in_node}] <= {1'b1, in_leaf, in_vote, in_left, in_right,
                                             in_feat, in_thr};
        node_q <= node_mem[node_raddr];
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser == REQ_WEIGHT)
            wgt_mem[in_tree] <= in_wgt;
        wgt_q <= wgt_mem[tree_reg];
    end

    // feature memory
    always_ff @(posedge clk)
    begin
        if (s_acc && s_tuser == REQ_FEAT)
            feat_mem[in_feat] <= in_fval;
        feat_q <= feat_mem[feat_raddr];
    end

    bte_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (mag),
        .total (total_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks boosted_tree_ensemble_score against an in-bench scoring model.
// Loads node tables, tree weights and feature vectors over the request
// stream, runs directed corner cases and then random ensembles, and compares
// every result with the scored expectation.
// ----------------------------------------------------------------------------
module testbench;

    import bte_pkg::*;

    localparam int STALL_LIMIT = 40000;
    localparam int RANDOM_ITEMS = 1850;

    typedef struct packed {
        logic [2:0]  status;
        logic        signal;
        logic [15:0] prob;
        logic [15:0] score;
    } score_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;
    logic [1:0]          s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;
    logic                cfg_we;
    logic [CNT_W-1:0]    cfg_wdata;

    // scoring model state
    bit                  nd_present [4096];
    bit                  nd_leaf [4096];
    bit                  nd_vote [4096];
    bit [5:0]            nd_left [4096];
    bit [5:0]            nd_right [4096];
    bit [4:0]            nd_feat [4096];
    logic signed [31:0]  nd_thr [4096];
    bit [31:0]           tree_wgt [64];
    logic signed [31:0]  feat_val [32];
    int                  feat_cnt;
    int                  trees_cfg;

    score_t              expected_scores [$];
    int                  errors;
    int                  items_sent;
    int                  burst_left;
    int                  idle_cycles;
    int                  cyc;
    int                  rdy_mode;

    boosted_tree_ensemble_score dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Walk one tree; returns status, vote through the output
    function automatic logic [2:0] walk_tree(input int t, output bit vote);
        int n;
        int a;
        n = 0;
        vote = 0;
        for (int v = 0; v < MAX_DEPTH; v++)
        begin
            a = t * 64 + n;
            if (!nd_present[a])
                return ST_MISSING;
            if (nd_leaf[a])
            begin
                vote = nd_vote[a];
                return ST_OK;
            end
            if (nd_feat[a] >= feat_cnt)
                return ST_NOFEAT;
            n = (feat_val[nd_feat[a]] <= nd_thr[a]) ? nd_left[a] : nd_right[a];
        end
        return ST_MISSING;
    endfunction

    // Score the ensemble over the trees in use
    function automatic score_t score_ensemble();
        score_t r;
        int ntrees;
        longint total;
        longint sum;
        longint mag;
        longint q;
        longint s;
        logic [2:0] st;
        bit vote;
        r = '0;
        ntrees = (trees_cfg > MAX_TREES) ? MAX_TREES : trees_cfg;
        total = 0;
        sum = 0;
        if (ntrees == 0)
        begin
            r.status = ST_NOTREES;
            return r;
        end
        for (int t = 0; t < ntrees; t++)
        begin
            st = walk_tree(t, vote);
            if (st != ST_OK)
            begin
                r.status = st;
                return r;
            end
            total += tree_wgt[t];
            if (vote)
                sum += tree_wgt[t];
            else
                sum -= tree_wgt[t];
        end
        if (total == 0)
        begin
            r.status = ST_ZEROWGT;
            return r;
        end
        mag = (sum < 0) ? -sum : sum;
        q = (mag << 15) / total;
        s = (sum < 0) ? -q : q;
        if (s > 32767)
            s = 32767;
        if (s < -32768)
            s = -32768;
        r.score = s[15:0];
        r.prob = 16'(s + 32768);
        r.signal = (sum > 0);
        r.status = ST_OK;
        return r;
    endfunction

    // Apply one accepted request to the model
    task automatic apply_request(input logic [1:0] kind, input logic [IN_W-1:0] d,
                                 input logic last);
        int a;
        int f;
        a = d[5:0] * 64 + d[11:6];
        f = d[30:26];
        if (kind == REQ_NODE)
        begin
            nd_present[a] = 1;
            nd_leaf[a] = d[12];
            nd_vote[a] = d[13];
            nd_left[a] = d[19:14];
            nd_right[a] = d[25:20];
            nd_feat[a] = d[30:26];
            nd_thr[a] = d[62:31];
        end
        else if (kind == REQ_WEIGHT)
            tree_wgt[d[5:0]] = d[94:63];
        else if (kind == REQ_FEAT)
        begin
            feat_val[f] = d[126:95];
            feat_cnt = f + 1;
            if (last)
            begin
                expected_scores.push_back(score_ensemble());
                feat_cnt = 0;
            end
        end
    endtask

    // Send one request, idling between bursts
    task automatic send_request(input logic [1:0] kind, input logic [IN_W-1:0] d,
                                input logic last);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= kind;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        apply_request(kind, d, last);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [IN_W-1:0] pack_fields(int t, int n, bit leaf, bit vote,
                                                    int l, int r, int f, logic [31:0] thr,
                                                    logic [31:0] w, logic [31:0] fv);
        logic [IN_W-1:0] d;
        d = '0;
        d[5:0] = 6'(t);
        d[11:6] = 6'(n);
        d[12] = leaf;
        d[13] = vote;
        d[19:14] = 6'(l);
        d[25:20] = 6'(r);
        d[30:26] = 5'(f);
        d[62:31] = thr;
        d[94:63] = w;
        d[126:95] = fv;
        return d;
    endfunction

    task automatic put_node(int t, int n, bit leaf, bit vote, int l, int r, int f,
                            logic [31:0] thr);
        send_request(REQ_NODE, pack_fields(t, n, leaf, vote, l, r, f, thr,
                                           $urandom, $urandom), 1'b0);
    endtask

    task automatic put_weight(int t, logic [31:0] w);
        send_request(REQ_WEIGHT, pack_fields(t, $urandom, $urandom, $urandom, $urandom,
                                             $urandom, $urandom, $urandom, w, $urandom), 1'b0);
    endtask

    task automatic put_feat(int f, logic [31:0] fv, bit last);
        send_request(REQ_FEAT, pack_fields($urandom, $urandom, $urandom, $urandom,
                                           $urandom, $urandom, f, $urandom, $urandom, fv),
                     last);
    endtask

    // Drop valid, wait for all results, then let the block go idle
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_scores.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_trees(int n);
        cfg_wdata <= CNT_W'(n);
        cfg_we <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        trees_cfg = n & 8'h7f;
    endtask

    // Complete tree of depth d at nodes 0.., optionally with one bad child
    task automatic build_tree(int t, int d, bit corrupt);
        int count;
        int lvl;
        int bad;
        count = (1 << (d + 1)) - 1;
        bad = corrupt ? $urandom_range(0, count - 1) : -1;
        for (int i = 0; i < count; i++)
        begin
            lvl = $clog2(i + 2) - 1;
            if (lvl < d && i != bad)
                put_node(t, i, 0, $urandom, 2 * i + 1, 2 * i + 2, $urandom_range(0, 31),
                         $urandom);
            else if (lvl < d)
                put_node(t, i, 0, $urandom, $urandom_range(0, 63), 2 * i + 2,
                         $urandom_range(0, 31), $urandom);
            else
                put_node(t, i, 1, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint exp);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // Compare each result with the oldest expectation
    always @(posedge clk)
    begin
        score_t got;
        score_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[35:0];
            if (expected_scores.size() == 0)
                report_mismatch("unexpected result status", got.status, -1);
            else
            begin
                exp = expected_scores.pop_front();
                if (got.score !== exp.score)
                    report_mismatch("score", $signed(got.score), $signed(exp.score));
                if (got.prob !== exp.prob)
                    report_mismatch("probability", got.prob, exp.prob);
                if (got.signal !== exp.signal)
                    report_mismatch("is_signal", got.signal, exp.signal);
                if (got.status !== exp.status)
                    report_mismatch("status", got.status, exp.status);
            end
        end
    end

    // Receiver stall pattern, switched among always ready, random and periodic modes
    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc % 256 == 0)
            rdy_mode <= $urandom_range(0, 2);
        case (rdy_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= $urandom_range(0, 1);
            default: m_tready <= ((cyc / 16) % 3) != 0;
        endcase
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic test_load_features();
        for (int i = 0; i < 32; i++)
            put_feat(i, $urandom, 1'b0);
    endtask

    task automatic test_no_trees();
        put_feat(31, 32'h7fffffff, 1'b1);
        settle();
    endtask

    // Threshold equal to the feature goes left; full weight saturates the score
    task automatic test_threshold_edge();
        write_trees(1);
        put_node(0, 0, 0, 0, 1, 2, 5, feat_val[5]);
        put_node(0, 1, 1, 1, 0, 0, 0, 0);
        put_node(0, 2, 1, 0, 0, 0, 0, 0);
        put_weight(0, 32'hffffffff);
        put_feat(31, 32'h80000000, 1'b1);
        put_node(0, 0, 0, 0, 1, 2, 5, feat_val[5] - 1);
        put_feat(31, 32'h0, 1'b1);
        settle();
    endtask

    task automatic test_missing_node();
        put_node(0, 0, 0, 0, 63, 63, 0, 32'h7fffffff);
        put_feat(31, $urandom, 1'b1);
        settle();
    endtask

    task automatic test_depth_overrun();
        put_node(0, 0, 0, 0, 0, 0, 1, 32'h80000000);
        put_feat(31, $urandom, 1'b1);
        settle();
    endtask

    task automatic test_feature_absent();
        put_node(0, 0, 0, 0, 1, 2, 31, 0);
        put_feat(0, $urandom, 1'b1);
        settle();
    endtask

    task automatic test_zero_weight();
        put_node(0, 0, 1, 1, 0, 0, 0, 0);
        put_weight(0, 0);
        put_feat(31, $urandom, 1'b1);
        settle();
    endtask

    task automatic test_ignored_type();
        put_weight(0, 32'h00010000);
        send_request(2'd3, {1'b0, {127{1'b1}}}, 1'b1);
        put_feat(31, $urandom, 1'b1);
        settle();
    endtask

    task automatic test_large_register();
        write_trees(127);
        put_feat(31, $urandom, 1'b1);
        settle();
        write_trees(64);
        put_feat(31, $urandom, 1'b1);
        settle();
    endtask

    // Random ensembles with random trees, weights and feature vectors
    task automatic test_random_ensembles();
        int n;
        int lim;
        int m;
        int pick;
        while (items_sent < RANDOM_ITEMS)
        begin
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 80)
                n = $urandom_range(1, 6);
            else if (pick < 90)
                n = 64;
            else if (pick < 95)
                n = 0;
            else
                n = $urandom_range(65, 127);
            write_trees(n);
            lim = (n > MAX_TREES) ? MAX_TREES : n;
            for (int t = 0; t < lim; t++)
            begin
                build_tree(t, (lim > 8) ? $urandom_range(0, 1) : $urandom_range(0, 3),
                           $urandom_range(0, 19) == 0);
                put_weight(t, ($urandom_range(0, 9) == 0) ? 32'h0 : $urandom);
            end
            repeat ($urandom_range(1, 4))
            begin
                if (lim > 0 && $urandom_range(0, 9) < 7)
                    build_tree($urandom_range(0, lim - 1), $urandom_range(0, 3),
                               $urandom_range(0, 19) == 0);
                // noise: stray writes and ignored kinds
                repeat ($urandom_range(0, 2))
                begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        put_node($urandom, $urandom, $urandom, $urandom, $urandom,
                                 $urandom, $urandom, $urandom);
                    else if (pick == 1)
                        put_weight($urandom, $urandom);
                    else
                        send_request(2'd3, {4{$urandom}}, $urandom);
                end
                if ($urandom_range(0, 9) < 7)
                begin
                    m = ($urandom_range(0, 1) != 0) ? 32 : $urandom_range(1, 32);
                    for (int i = 0; i < m; i++)
                        put_feat(i, $urandom, i == m - 1);
                end
                else
                    put_feat(31, $urandom, 1'b1);
            end
        end
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        feat_cnt = 0;
        trees_cfg = 0;
        for (int i = 0; i < 4096; i++)
            nd_present[i] = 0;
        for (int i = 0; i < 64; i++)
            tree_wgt[i] = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_load_features();
        test_no_trees();
        test_threshold_edge();
        test_missing_node();
        test_depth_overrun();
        test_feature_absent();
        test_zero_weight();
        test_ignored_type();
        test_large_register();
        test_random_ensembles();

        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bte_pkg.sv
hw/rtl/bte_div.sv
hw/rtl/boosted_tree_ensemble_score.sv
dv/testbench.sv
